[design/cbps_pkg.sv]
package cbps_pkg;

   typedef struct packed {
      logic signed [31:0] tilt_angle;
      logic signed [31:0] tilt_rate;
      logic signed [31:0] throttle_cmd;
      logic signed [31:0] turn_cmd;
      logic [15:0]        period;
      logic               skip_slew;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic signed [31:0] left_speed;
      logic signed [31:0] right_speed;
      logic signed [15:0] target_tilt;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_SPEED_KP     = 3'd0,
      CSR_SPEED_INV_TI = 3'd1,
      CSR_SPEED_TD     = 3'd2,
      CSR_ANGLE_KP     = 3'd3,
      CSR_ANGLE_INV_TI = 3'd4,
      CSR_ANGLE_TD     = 3'd5,
      CSR_SPEED_LIMITS = 3'd6,
      CSR_MODE_BITS    = 3'd7
   } csr_index_type;

   localparam logic [31:0] SPEED_LIMITS_RESET = 32'd26214800;
   localparam logic [3:0]  MODE_BITS_RESET    = 4'd2;
   localparam logic signed [31:0] RAD_TO_DEG_Q = 32'sd3754936;
   localparam logic signed [33:0] TILT_LIMIT_Q = 34'sd16384;
   localparam logic signed [33:0] ONE_Q        = 34'sd65536;
   localparam logic signed [33:0] MAX32        = 34'sd2147483647;
   localparam logic signed [33:0] MIN32        = -34'sd2147483648;

   // multiplier product rounding modes
   typedef enum logic [1:0] {
      MR_Q16,
      MR_Q17,
      MR_RAW
   } mul_mode_type;

   typedef struct packed {
      logic               start;
      mul_mode_type       mode;
      logic signed [33:0] a;
      logic signed [33:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               start;
      logic signed [47:0] num;
      logic [15:0]        den;
   } div_req_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_PREP,
      ST_RATE,
      ST_SERR,
      ST_FH,
      ST_FD,
      ST_FAB,
      ST_F0,
      ST_F1,
      ST_F2,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_SUM,
      ST_MIX,
      ST_SLEW,
      ST_DONE
   } state_type;

   function automatic logic signed [33:0] sat32(input logic signed [65:0] v);
      if (v > 66'(MAX32)) sat32 = MAX32;
      else if (v < 66'(MIN32)) sat32 = MIN32;
      else sat32 = v[33:0];
   endfunction

   function automatic logic signed [33:0] clipm(input logic signed [33:0] v,
                                                input logic signed [33:0] m);
      if (v > m) clipm = m;
      else if (v < -m) clipm = -m;
      else clipm = v;
   endfunction

endpackage

[design/cbps_mul.sv]
module cbps_mul
   import cbps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mul_req_type        req,
   output logic               done,
   output logic signed [33:0] result
);

   logic signed [67:0] prod_ff, prod_in;
   mul_mode_type       mode_ff, mode_in;
   logic               busy_ff, busy_in;
   logic signed [67:0] rnd;

   assign prod_in = req.start ? 68'(req.a) * 68'(req.b) : prod_ff;
   assign mode_in = req.start ? req.mode : mode_ff;
   assign busy_in = req.start;

   always_comb begin
      case (mode_ff)
         MR_Q16:  rnd = (prod_ff + 68'sd32768) >>> 16;
         MR_Q17:  rnd = (prod_ff + 68'sd65536) >>> 17;
         default: rnd = prod_ff;
      endcase
      if (rnd > 68'(MAX32)) result = MAX32;
      else if (rnd < 68'(MIN32)) result = MIN32;
      else result = rnd[33:0];
   end

   assign done = busy_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      mode_ff <= mode_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

endmodule

[design/cbps_div.sv]
module cbps_div
   import cbps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_req_type        req,
   output logic               done,
   output logic signed [33:0] result
);

   // restoring divide, one quotient bit per cycle, truncation toward zero
   logic [47:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic [16:0] trial;
   logic signed [48:0] q;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      trial  = {rem_ff[15:0], quo_ff[47]};
      if (req.start) begin
         neg_in = req.num[47];
         quo_in = req.num[47] ? 48'(-req.num) : req.num;
         rem_in = '0;
         den_in = req.den;
         cnt_in = 6'd48;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) run_in = 1'b0;
      end
   end

   assign done = run_ff && (cnt_ff == 6'd1) && !req.start;
   assign q = neg_ff ? -$signed({1'b0, quo_in}) : $signed({1'b0, quo_in});
   assign result = sat32(66'(q));

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[design/cascaded_balance_pid_slew.sv]
// channel   direction  payload
// req       in         req_type: tilt, rate, throttle, turn, period, skip_slew, restart
// rsp       out        rsp_type: left and right speed, target tilt
// csr       in         index and 32-bit data, write only
//
// the result takes longest with both loops on, less with the speed loop off and least
// with balancing off, as the bit-serial divider runs once per PID loop and the
// multiplier is shared by every product
// req_ready is low from acceptance until the result has been transferred
// reset is synchronous: registers to their reset values, PID history and speeds to zero
module cascaded_balance_pid_slew
   import cbps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic signed [31:0] kp_ff [2], iti_ff [2], td_ff [2];
   logic [31:0] lim_ff;
   logic [3:0]  mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff[0] <= '0; kp_ff[1] <= '0;
         iti_ff[0] <= '0; iti_ff[1] <= '0;
         td_ff[0] <= '0; td_ff[1] <= '0;
         lim_ff <= SPEED_LIMITS_RESET;
         mode_ff <= MODE_BITS_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SPEED_KP:     kp_ff[0] <= csr_data;
            CSR_SPEED_INV_TI: iti_ff[0] <= csr_data;
            CSR_SPEED_TD:     td_ff[0] <= csr_data;
            CSR_ANGLE_KP:     kp_ff[1] <= csr_data;
            CSR_ANGLE_INV_TI: iti_ff[1] <= csr_data;
            CSR_ANGLE_TD:     td_ff[1] <= csr_data;
            CSR_SPEED_LIMITS: lim_ff <= csr_data;
            CSR_MODE_BITS:    mode_ff <= csr_data[3:0];
            default:          ;
         endcase
      end
   end

   state_type state_ff, state_in;
   req_type   req_ff;
   logic      loop_ff, loop_in;   // 0 speed loop, 1 angle loop
   logic signed [33:0] ms, acc, thr, turn;
   logic signed [33:0] serr1_ff, serr2_ff, tprev_ff, aerr1_ff, aerr2_ff;
   logic signed [33:0] lms_ff, rms_ff;
   logic signed [33:0] speed_ff, err_ff, h_ff, d_ff, b_ff, a_sum;
   logic signed [33:0] f0_ff, f1_ff, f2_ff, acc_ff, target_ff;
   logic signed [33:0] left_ff, right_ff;
   logic signed [15:0] tgt_out_ff;
   logic               rsp_valid_ff;
   logic signed [33:0] kp, iti, td, e1, e2, per;
   mul_req_type mreq;
   div_req_type dreq;
   logic mdone, ddone;
   logic signed [33:0] mres, dres;

   assign ms   = sat32(66'($signed({1'b0, lim_ff[15:0], 16'd0})));
   assign acc  = sat32(66'($signed({1'b0, lim_ff[31:16], 16'd0})));
   assign thr  = clipm(34'(req_ff.throttle_cmd), ms);
   assign turn = clipm(34'(req_ff.turn_cmd), ms);
   assign per  = (req_ff.period == 16'd0) ? 34'sd1 : 34'($signed({1'b0, req_ff.period}));
   // gains follow the loop being entered so requests issued on a loop change see them
   assign kp   = 34'(kp_ff[loop_in]);
   assign iti  = 34'(iti_ff[loop_in]);
   assign td   = 34'(td_ff[loop_in]);
   assign e1   = loop_in ? aerr1_ff : serr1_ff;
   assign e2   = loop_in ? aerr2_ff : serr2_ff;
   assign a_sum = sat32(66'(ONE_Q) + 66'(h_ff) + 66'(d_ff));

   cbps_mul u_mul (.clock, .reset, .req(mreq), .done(mdone), .result(mres));
   cbps_div u_div (.clock, .reset, .req(dreq), .done(ddone), .result(dres));

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{left_speed: lms_ff[31:0], right_speed: rms_ff[31:0],
                        target_tilt: tgt_out_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      loop_in  = loop_ff;
      case (state_ff)
         ST_IDLE: if (req_valid && req_ready) state_in = ST_PREP;
         ST_PREP: begin
            loop_in = 1'b0;
            if (!mode_ff[0]) state_in = ST_MIX;
            else if (mode_ff[1]) state_in = ST_RATE;
            else begin
               state_in = ST_FH;
               loop_in = 1'b1;
            end
         end
         ST_RATE: if (mdone) state_in = ST_SERR;
         ST_SERR: state_in = ST_FH;
         ST_FH:   if (mdone) state_in = ST_FD;
         ST_FD:   if (ddone) state_in = ST_FAB;
         ST_FAB:  state_in = ST_F0;
         ST_F0:   if (mdone) state_in = ST_F1;
         ST_F1:   if (mdone) state_in = ST_F2;
         ST_F2:   if (mdone) state_in = ST_P0;
         ST_P0:   if (mdone) state_in = ST_P1;
         ST_P1:   if (mdone) state_in = ST_P2;
         ST_P2:   if (mdone) state_in = ST_SUM;
         ST_SUM: begin
            if (loop_ff) state_in = ST_MIX;
            else begin
               state_in = ST_FH;
               loop_in = 1'b1;
            end
         end
         ST_MIX:  state_in = ST_SLEW;
         ST_SLEW: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // unit requests, issued on entry to each wait state
   logic entering;
   assign entering = (state_in != state_ff);

   always_comb begin
      mreq = '{start: 1'b0, mode: MR_Q16, a: '0, b: '0};
      dreq = '{start: 1'b0, num: '0, den: '0};
      if (entering) begin
         case (state_in)
            ST_RATE: mreq = '{1'b1, MR_Q16, 34'(req_ff.tilt_rate), 34'(RAD_TO_DEG_Q)};
            ST_FH:   mreq = '{1'b1, MR_Q17, iti, per};
            ST_FD:   dreq = '{1'b1, {td[31:0], 16'd0}, per[15:0]};
            ST_F0:   mreq = '{1'b1, MR_Q16, kp, a_sum};
            ST_F1:   mreq = '{1'b1, MR_Q16, kp, b_ff};
            ST_F2:   mreq = '{1'b1, MR_Q16, kp, d_ff};
            ST_P0:   mreq = '{1'b1, MR_Q16, f0_ff, err_ff};
            ST_P1:   mreq = '{1'b1, MR_Q16, f1_ff, e1};
            ST_P2:   mreq = '{1'b1, MR_Q16, f2_ff, e2};
            default: ;
         endcase
      end
   end

   logic signed [33:0] gl, gr, sum_all, outv, lw, rw, ls, rs;
   always_comb begin
      gl = mode_ff[2] ? -lms_ff : lms_ff;
      gr = mode_ff[3] ? -rms_ff : rms_ff;
      // the three products are summed unsaturated, one saturation at the end
      sum_all = sat32(66'(acc_ff) + 66'(loop_ff ? speed_ff : tprev_ff));
      outv = mode_ff[0] ? clipm(acc_ff, ms) : thr;
      lw = clipm(outv + turn, ms);
      rw = clipm(outv - turn, ms);
      if (left_ff > lms_ff + acc) ls = sat32(66'(lms_ff + acc));
      else if (left_ff < lms_ff - acc) ls = sat32(66'(lms_ff - acc));
      else ls = left_ff;
      if (right_ff > rms_ff + acc) rs = sat32(66'(rms_ff + acc));
      else if (right_ff < rms_ff - acc) rs = sat32(66'(rms_ff - acc));
      else rs = right_ff;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (req_valid && req_ready) req_ff <= req_data;
         ST_PREP: begin
            speed_ff <= 34'((66'(gl) + 66'(gr)) / 2);
            target_ff <= '0;
            err_ff <= '0;
            if (req_ff.restart) begin
               serr1_ff <= '0; serr2_ff <= '0; tprev_ff <= '0;
               aerr1_ff <= '0; aerr2_ff <= '0;
            end
         end
         ST_RATE: if (mdone) h_ff <= mres;
         ST_SERR: err_ff <= sat32(66'(speed_ff) - 66'(h_ff) - 66'(thr));
         ST_FH: begin
            if (loop_ff) err_ff <= sat32(66'(target_ff) - 66'(req_ff.tilt_angle));
            if (!mode_ff[1] && loop_ff && state_ff != state_in) begin
               serr2_ff <= serr1_ff; serr1_ff <= '0; tprev_ff <= '0;
            end
            if (mdone) h_ff <= mres;
         end
         ST_FD: if (ddone) d_ff <= dres;
         ST_FAB: begin
            b_ff <= sat32(66'(h_ff) - 66'(d_ff) - 66'(d_ff) - 66'(ONE_Q));
         end
         ST_F0: if (mdone) f0_ff <= mres;
         ST_F1: if (mdone) f1_ff <= mres;
         ST_F2: if (mdone) f2_ff <= mres;
         ST_P0: if (mdone) acc_ff <= mres;
         ST_P1: if (mdone) acc_ff <= acc_ff + mres;
         ST_P2: if (mdone) acc_ff <= acc_ff + mres;
         ST_SUM: begin
            if (!loop_ff) begin
               target_ff <= clipm(sum_all, TILT_LIMIT_Q);
               tprev_ff <= clipm(sum_all, TILT_LIMIT_Q);
               serr2_ff <= serr1_ff;
               serr1_ff <= err_ff;
            end else begin
               acc_ff <= sum_all;
               aerr2_ff <= aerr1_ff;
               aerr1_ff <= err_ff;
            end
         end
         ST_MIX: begin
            left_ff <= mode_ff[2] ? -lw : lw;
            right_ff <= mode_ff[3] ? -rw : rw;
         end
         default: ;
      endcase
      if (reset) begin
         serr1_ff <= '0; serr2_ff <= '0; tprev_ff <= '0;
         aerr1_ff <= '0; aerr2_ff <= '0;
         lms_ff <= '0; rms_ff <= '0;
      end else if (state_ff == ST_SLEW) begin
         lms_ff <= req_ff.skip_slew ? left_ff : ls;
         rms_ff <= req_ff.skip_slew ? right_ff : rs;
         tgt_out_ff <= mode_ff[0] ? target_ff[15:0] : 16'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         loop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         loop_ff <= loop_in;
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE)) else $error("stray response");
   a_target_range: assert property (@(posedge clock) disable iff (reset)
      (target_ff <= TILT_LIMIT_Q && target_ff >= -TILT_LIMIT_Q) || state_ff == ST_IDLE
      || state_ff == ST_PREP) else $error("target tilt out of range");

endmodule

[bench/tb.sv]
module tb;
   import cbps_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class balance_scoreboard;
      // controller copy
      longint s_kp, s_iti, s_td, a_kp, a_iti, a_td;
      logic [31:0] limits;
      logic [3:0] mode;
      longint serr1, serr2, tgt_prev, aerr1, aerr2, left_q, right_q;
      rsp_type pending[$];
      int errors, checked;

      function new();
         s_kp = 0; s_iti = 0; s_td = 0; a_kp = 0; a_iti = 0; a_td = 0;
         limits = SPEED_LIMITS_RESET; mode = MODE_BITS_RESET;
         serr1 = 0; serr2 = 0; tgt_prev = 0; aerr1 = 0; aerr2 = 0;
         left_q = 0; right_q = 0; errors = 0; checked = 0;
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint clip(longint v, longint m);
         if (v > m) return m;
         if (v < -m) return -m;
         return v;
      endfunction

      // arithmetic shift floors; add half first for round half up
      function longint rshift(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function longint qmul(longint a, longint b);
         return sat(rshift(a * b, 16));
      endfunction

      function void gains(longint kp, longint iti, longint td, longint per,
                          output longint f0, output longint f1, output longint f2);
         longint h, d;
         h = sat(rshift(iti * per, 17));
         d = sat((td * 65536) / per);
         f0 = qmul(kp, sat(65536 + h + d));
         f1 = qmul(kp, sat(h - 2 * d - 65536));
         f2 = qmul(kp, d);
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] v);
         longint sv;
         sv = longint'(signed'(v));
         case (idx)
            CSR_SPEED_KP:     s_kp = sv;
            CSR_SPEED_INV_TI: s_iti = sv;
            CSR_SPEED_TD:     s_td = sv;
            CSR_ANGLE_KP:     a_kp = sv;
            CSR_ANGLE_INV_TI: a_iti = sv;
            CSR_ANGLE_TD:     a_td = sv;
            CSR_SPEED_LIMITS: limits = v;
            CSR_MODE_BITS:    mode = v[3:0];
            default: ;
         endcase
      endfunction

      function longint slew(longint cur, longint want, longint acc);
         if (want > cur + acc) return sat(cur + acc);
         if (want < cur - acc) return sat(cur - acc);
         return want;
      endfunction

      function void note_request(req_type r);
         longint ang, thr, turn, per, ms, acc, l, rr, tgt, spd, serr, aerr, o, f0, f1, f2;
         rsp_type e;
         ang = longint'(r.tilt_angle);
         thr = longint'(r.throttle_cmd);
         turn = longint'(r.turn_cmd);
         per = (r.period == 0) ? 1 : longint'(r.period);
         ms = sat(longint'(limits[15:0]) * 65536);
         acc = sat(longint'(limits[31:16]) * 65536);
         tgt = 0;
         if (r.restart) begin
            serr1 = 0; serr2 = 0; tgt_prev = 0; aerr1 = 0; aerr2 = 0;
         end
         thr = clip(thr, ms);
         turn = clip(turn, ms);
         if (!mode[0]) begin
            l = clip(thr + turn, ms);
            rr = clip(thr - turn, ms);
         end else begin
            spd = ((mode[2] ? -left_q : left_q) + (mode[3] ? -right_q : right_q)) / 2;
            serr = 0;
            if (mode[1]) begin
               serr = sat(spd - sat(rshift(longint'(r.tilt_rate) * 3754936, 16)) - thr);
               gains(s_kp, s_iti, s_td, per, f0, f1, f2);
               tgt = sat(qmul(f0, serr) + qmul(f1, serr1) + qmul(f2, serr2) + tgt_prev);
               tgt = clip(tgt, 16384);
            end
            serr2 = serr1; serr1 = serr; tgt_prev = tgt;
            aerr = sat(tgt - ang);
            gains(a_kp, a_iti, a_td, per, f0, f1, f2);
            o = sat(qmul(f0, aerr) + qmul(f1, aerr1) + qmul(f2, aerr2) + spd);
            o = clip(o, ms);
            l = clip(o + turn, ms);
            rr = clip(o - turn, ms);
            aerr2 = aerr1; aerr1 = aerr;
         end
         if (mode[2]) l = -l;
         if (mode[3]) rr = -rr;
         if (r.skip_slew) begin
            left_q = l; right_q = rr;
         end else begin
            left_q = slew(left_q, l, acc);
            right_q = slew(right_q, rr, acc);
         end
         e.left_speed = left_q[31:0];
         e.right_speed = right_q[31:0];
         e.target_tilt = tgt[15:0];
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing outstanding: %h", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.left_speed !== e.left_speed) begin
            $error("left_speed expected %0d got %0d", e.left_speed, a.left_speed);
            errors++;
         end
         if (a.right_speed !== e.right_speed) begin
            $error("right_speed expected %0d got %0d", e.right_speed, a.right_speed);
            errors++;
         end
         if (a.target_tilt !== e.target_tilt) begin
            $error("target_tilt expected %0d got %0d", e.target_tilt, a.target_tilt);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   req_type req_data = '0;
   rsp_type rsp_data;
   logic csr_write = 0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   balance_scoreboard board = new();
   int idle_cycles = 0, sent = 0;
   bit hold_off = 0;

   cascaded_balance_pid_slew uut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("timeout with %0d results outstanding", board.pending.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall before each transfer, or a long hold-off on request
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         w = $urandom_range(0, 16);
         if ($urandom_range(0, 3) == 0) w = 0;
         if (w > 0) begin
            rsp_ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && !hold_off);
      end
   end

   // valid stays up after a transfer only when the next item follows at once
   task automatic send(req_type r, bit quick);
      int w;
      w = quick ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
         req_valid <= 0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_put(csr_index_type idx, logic [31:0] v);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      board.write_reg(idx, v);
      csr_write <= 0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word(int k);
      case (k)
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return $urandom_range(0, 131072) - 65536;
         4: return $urandom_range(0, 8388608) - 4194304;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type r;
      r.tilt_angle = rand_word($urandom_range(0, 7));
      r.tilt_rate = rand_word($urandom_range(0, 7));
      r.throttle_cmd = rand_word($urandom_range(0, 7));
      r.turn_cmd = rand_word($urandom_range(0, 7));
      case ($urandom_range(0, 4))
         0: r.period = 16'd1;
         1: r.period = 16'hffff;
         2: r.period = 16'd0;
         default: r.period = 16'($urandom_range(1, 65535));
      endcase
      r.skip_slew = ($urandom_range(0, 3) == 0);
      r.restart = ($urandom_range(0, 15) == 0);
      return r;
   endfunction

   task automatic random_gains(int k);
      csr_put(CSR_SPEED_KP, rand_word(k));
      csr_put(CSR_SPEED_INV_TI, rand_word($urandom_range(2, 7)));
      csr_put(CSR_SPEED_TD, rand_word($urandom_range(2, 7)));
      csr_put(CSR_ANGLE_KP, rand_word(k));
      csr_put(CSR_ANGLE_INV_TI, rand_word($urandom_range(2, 7)));
      csr_put(CSR_ANGLE_TD, rand_word($urandom_range(2, 7)));
   endtask

   initial begin
      req_type r;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset settings first, then extremes
      r = '0; r.period = 16'd1000;
      send(r, 1'b1);
      r.throttle_cmd = 32'h7fffffff; r.turn_cmd = 32'h80000000; r.period = 16'd0;
      send(r, 1'b0);
      r.skip_slew = 1; send(r, 1'b0);
      drain();
      csr_put(CSR_MODE_BITS, 32'h3);
      csr_put(CSR_SPEED_KP, 32'h00010000);
      csr_put(CSR_SPEED_INV_TI, 32'h00008000);
      csr_put(CSR_SPEED_TD, 32'h00000100);
      csr_put(CSR_ANGLE_KP, 32'h00200000);
      csr_put(CSR_ANGLE_INV_TI, 32'h00010000);
      csr_put(CSR_ANGLE_TD, 32'h00001000);
      r = '0; r.period = 16'd655; r.tilt_angle = 32'h00002000;
      send(r, 1'b0);
      r.tilt_rate = 32'h7fffffff; r.tilt_angle = 32'h80000000; send(r, 1'b0);
      r.tilt_rate = 32'h80000000; r.tilt_angle = 32'h7fffffff; r.period = 16'hffff;
      send(r, 1'b0);
      r.restart = 1; r.period = 16'd1; send(r, 1'b0);
      drain();
      // large limits saturate, speed loop off, both inversions
      csr_put(CSR_SPEED_LIMITS, 32'hffffffff);
      csr_put(CSR_MODE_BITS, 32'hd);
      r = rand_req(); send(r, 1'b0);
      r.skip_slew = 1; send(r, 1'b0);
      drain();
      csr_put(CSR_SPEED_LIMITS, 32'h00010001);
      csr_put(CSR_MODE_BITS, 32'h7);
      repeat (4) send(rand_req(), 1'b0);
      drain();
      csr_put(CSR_SPEED_LIMITS, 32'h0);
      csr_put(CSR_MODE_BITS, 32'h8);
      repeat (3) send(rand_req(), 1'b0);
      drain();

      // random phases with new settings between them
      for (int ph = 0; ph < 12; ph++) begin
         random_gains($urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0: csr_put(CSR_SPEED_LIMITS, $urandom);
            1: csr_put(CSR_SPEED_LIMITS, 32'hffffffff);
            default: csr_put(CSR_SPEED_LIMITS,
                             {16'($urandom_range(1, 50)), 16'($urandom_range(1, 800))});
         endcase
         csr_put(CSR_MODE_BITS, ph == 0 ? 32'h0 : 32'($urandom_range(0, 15)));
         if (ph == 3) hold_off = 1;
         for (int i = 0; i < 32; i++) send(rand_req(), (ph % 3) == 1);
         drain();
      end

      $display("sent %0d control ticks over 17 setting phases, %0d results checked",
               sent, board.checked);
      $display("gains, limits, modes, restarts and slew bypass were all exercised");
      if (board.errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule

[sim.f]
design/cbps_pkg.sv
design/cbps_mul.sv
design/cbps_div.sv
design/cascaded_balance_pid_slew.sv
bench/tb.sv
